### hw/rtl/imm_pkg.sv
// Shared types, constants and helpers for the integer matrix multiplier.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package imm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;

  // Widths fixed by the item fields
  localparam int OP_W      = 2;
  localparam int COORD_W   = 3;
  localparam int VALUE_W   = 16;
  localparam int SUM_BITS  = 35;
  localparam int CFG_W     = 4;

  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int PROD_W    = 2 * ELEM_BITS;

  // APB register map
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_SEL_W = 2;
  localparam logic [REG_SEL_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [REG_SEL_W-1:0] REG_B_COLS = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2
  } op_e;

  typedef logic        [CFG_W-1:0]     cfg_t;
  typedef logic        [IDX_W-1:0]     idx_t;
  typedef logic        [ADDR_W-1:0]    addr_t;
  typedef logic        [COORD_W-1:0]   coord_t;
  typedef logic signed [ELEM_BITS-1:0] elem_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;
  typedef logic        [PDATA_W-1:0]   pdata_t;

  // Last usable index for a dimension register: zero acts as one, large values clamp
  function automatic idx_t dim_last(cfg_t r);
    idx_t res;
    if (r == '0) begin
      res = '0;
    end else if (int'(r) > MAX_DIM) begin
      res = idx_t'(MAX_DIM - 1);
    end else begin
      res = idx_t'(r - cfg_t'(1));
    end
    return res;
  endfunction

endpackage

### hw/rtl/imm_in_if.sv
// Request channel of the matrix multiplier: valid/ready plus one load or compute request.
// Depends on imm_pkg for field widths.
interface imm_in_if;
  logic                            valid;
  logic                            ready;
  logic [imm_pkg::OP_W-1:0]        operation;
  logic [imm_pkg::COORD_W-1:0]     row_index;
  logic [imm_pkg::COORD_W-1:0]     col_index;
  logic signed [imm_pkg::VALUE_W-1:0] element_value;

  modport source (output valid, operation, row_index, col_index, element_value,
                  input ready);
  modport sink   (input valid, operation, row_index, col_index, element_value,
                  output ready);
endinterface

### hw/rtl/imm_out_if.sv
// Result channel of the matrix multiplier: valid/ready plus one C element or error.
// Depends on imm_pkg for field widths.
interface imm_out_if;
  logic                                valid;
  logic                                ready;
  logic [imm_pkg::COORD_W-1:0]         out_row;
  logic [imm_pkg::COORD_W-1:0]         out_col;
  logic signed [imm_pkg::SUM_BITS-1:0] dot_sum;
  logic                                last_element;
  logic                                dim_error;

  modport source (output valid, out_row, out_col, dot_sum, last_element, dim_error,
                  input ready);
  modport sink   (input valid, out_row, out_col, dot_sum, last_element, dim_error,
                  output ready);
endinterface

### hw/rtl/integer_matrix_multiplier.sv
// Load request: one per cycle. Compute request: each C element passes through
// the single shared multiply-accumulate unit (one product per cycle from the A
// and B store read ports), then waits out any output stall; a dimension error
// skips the unit and gives one error result. Ready only while idle.
// Async active-low reset: dimension registers to 8, sequencer idle; the A and B
// stores are not cleared and hold garbage until written.
module integer_matrix_multiplier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  imm_in_if.sink                        req_i,
  imm_out_if.source                     rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [imm_pkg::PADDR_W-1:0]   paddr,
  input  logic [imm_pkg::PDATA_W-1:0]   pwdata,
  output logic [imm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_EMIT
  } state_e;

  // ---------------- configuration ----------------
  imm_pkg::cfg_t a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [imm_pkg::REG_SEL_W-1:0] reg_sel;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[imm_pkg::REG_SEL_W+1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= imm_pkg::cfg_t'(8);
      a_cols_q <= imm_pkg::cfg_t'(8);
      b_rows_q <= imm_pkg::cfg_t'(8);
      b_cols_q <= imm_pkg::cfg_t'(8);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        imm_pkg::REG_A_ROWS: a_rows_q <= pwdata[imm_pkg::CFG_W-1:0];
        imm_pkg::REG_A_COLS: a_cols_q <= pwdata[imm_pkg::CFG_W-1:0];
        imm_pkg::REG_B_ROWS: b_rows_q <= pwdata[imm_pkg::CFG_W-1:0];
        imm_pkg::REG_B_COLS: b_cols_q <= pwdata[imm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      imm_pkg::REG_A_ROWS: prdata = imm_pkg::pdata_t'(a_rows_q);
      imm_pkg::REG_A_COLS: prdata = imm_pkg::pdata_t'(a_cols_q);
      imm_pkg::REG_B_ROWS: prdata = imm_pkg::pdata_t'(b_rows_q);
      imm_pkg::REG_B_COLS: prdata = imm_pkg::pdata_t'(b_cols_q);
      default:             prdata = '0;
    endcase
  end

  // ---------------- request decode ----------------
  state_e state_q;
  logic   req_acc, idx_ok, wr_a, wr_b, start;
  imm_pkg::addr_t wr_addr;
  imm_pkg::elem_t wr_data;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign idx_ok      = (int'(req_i.row_index) < imm_pkg::MAX_DIM) &&
                       (int'(req_i.col_index) < imm_pkg::MAX_DIM);
  assign wr_addr     = {req_i.row_index[imm_pkg::IDX_W-1:0],
                        req_i.col_index[imm_pkg::IDX_W-1:0]};
  assign wr_data     = imm_pkg::elem_t'(req_i.element_value);

  always_comb begin
    wr_a  = 1'b0;
    wr_b  = 1'b0;
    start = 1'b0;
    unique case (req_i.operation)
      imm_pkg::OP_WRITE_A: wr_a  = req_acc && idx_ok;
      imm_pkg::OP_WRITE_B: wr_b  = req_acc && idx_ok;
      imm_pkg::OP_COMPUTE: start = req_acc;
      default: ;
    endcase
  end

  // ---------------- element stores ----------------
  imm_pkg::elem_t mem_a [imm_pkg::MEM_DEPTH];
  imm_pkg::elem_t mem_b [imm_pkg::MEM_DEPTH];
  imm_pkg::elem_t a_rd_q, b_rd_q;
  imm_pkg::idx_t  i_q, j_q, k_q;

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    a_rd_q <= mem_a[{i_q, k_q}];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    b_rd_q <= mem_b[{k_q, j_q}];
  end

  // ---------------- shared MAC ----------------
  imm_pkg::prod_t prod_q;
  imm_pkg::sum_t  acc_q;
  logic v1_q, v2_q, f1_q, f2_q, l1_q, l2_q, done_q;

  always_ff @(posedge clk_i) begin
    prod_q <= imm_pkg::prod_t'(a_rd_q) * imm_pkg::prod_t'(b_rd_q);
    if (v2_q) begin
      acc_q <= (f2_q ? imm_pkg::sum_t'(0) : acc_q) + imm_pkg::sum_t'(prod_q);
    end
  end

  // ---------------- sequencer and result register ----------------
  imm_pkg::idx_t ar_last_q, ac_last_q, bc_last_q;
  logic          err_q, issue, out_free, elem_last;

  assign issue     = (state_q == S_MAC);
  assign out_free  = !rsp_o.valid || rsp_o.ready;
  assign elem_last = (i_q == ar_last_q) && (j_q == bc_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      i_q                <= '0;
      j_q                <= '0;
      k_q                <= '0;
      ar_last_q          <= '0;
      ac_last_q          <= '0;
      bc_last_q          <= '0;
      err_q              <= 1'b0;
      v1_q               <= 1'b0;
      v2_q               <= 1'b0;
      f1_q               <= 1'b0;
      f2_q               <= 1'b0;
      l1_q               <= 1'b0;
      l2_q               <= 1'b0;
      done_q             <= 1'b0;
      rsp_o.valid        <= 1'b0;
      rsp_o.out_row      <= '0;
      rsp_o.out_col      <= '0;
      rsp_o.dot_sum      <= '0;
      rsp_o.last_element <= 1'b0;
      rsp_o.dim_error    <= 1'b0;
    end else begin
      // product pipeline tags: read, multiply, accumulate
      v1_q   <= issue;
      f1_q   <= (k_q == '0);
      l1_q   <= (k_q == ac_last_q);
      v2_q   <= v1_q;
      f2_q   <= f1_q;
      l2_q   <= l1_q;
      done_q <= v2_q && l2_q;

      // in S_EMIT a taken result is replaced by the next one below
      if (rsp_o.valid && rsp_o.ready && (state_q != S_EMIT)) begin
        rsp_o.valid <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            i_q       <= '0;
            j_q       <= '0;
            k_q       <= '0;
            ar_last_q <= imm_pkg::dim_last(a_rows_q);
            ac_last_q <= imm_pkg::dim_last(a_cols_q);
            bc_last_q <= imm_pkg::dim_last(b_cols_q);
            err_q     <= (imm_pkg::dim_last(a_cols_q) != imm_pkg::dim_last(b_rows_q));
            state_q   <= (imm_pkg::dim_last(a_cols_q) != imm_pkg::dim_last(b_rows_q))
                         ? S_EMIT : S_MAC;
          end
        end
        S_MAC: begin
          if (k_q == ac_last_q) begin
            k_q     <= '0;
            state_q <= S_DRAIN;
          end else begin
            k_q <= k_q + imm_pkg::idx_t'(1);
          end
        end
        S_DRAIN: begin
          if (done_q) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_o.valid        <= 1'b1;
            rsp_o.out_row      <= imm_pkg::coord_t'(i_q);
            rsp_o.out_col      <= imm_pkg::coord_t'(j_q);
            rsp_o.dot_sum      <= err_q ? imm_pkg::sum_t'(0) : acc_q;
            rsp_o.last_element <= err_q || elem_last;
            rsp_o.dim_error    <= err_q;
            if (err_q || elem_last) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_MAC;
              if (j_q == bc_last_q) begin
                j_q <= '0;
                i_q <= i_q + imm_pkg::idx_t'(1);
              end else begin
                j_q <= j_q + imm_pkg::idx_t'(1);
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
